>>> design/dqsc_pkg.sv
// Shared types, register indexes and reset values for the dual quadrature steering block.
package dqsc_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int DUTY_W          = 16;
  localparam int GAIN_W          = 8;
  localparam int DIFF_OUT_W      = 17;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;

  typedef logic [DUTY_W-1:0]            duty_t;
  typedef logic [GAIN_W-1:0]            gain_t;
  typedef logic signed [DIFF_OUT_W-1:0] diff_out_t;
  typedef logic [CFG_IDX_W-1:0]         cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]        cfg_data_t;

  localparam cfg_idx_t REG_BASE_DUTY     = 2'd0;
  localparam cfg_idx_t REG_GAIN_QUARTERS = 2'd1;
  localparam cfg_idx_t REG_DUTY_TOP      = 2'd2;

  localparam duty_t BASE_DUTY_RST = 16'd30;
  localparam gain_t GAIN_RST      = 8'd10;
  localparam duty_t DUTY_TOP_RST  = 16'd255;

endpackage

>>> design/dqsc_cfg_if.sv
// Configuration write channel: register index and write data.
interface dqsc_cfg_if;
  import dqsc_pkg::*;

  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> design/dqsc_in_if.sv
// Input channel: one pin sample of both wheel encoders.
interface dqsc_in_if;
  logic valid;
  logic ready;
  logic right_xor;
  logic right_b;
  logic left_xor;
  logic left_b;

  modport source (output valid, right_xor, right_b, left_xor, left_b, input ready);
  modport sink   (input valid, right_xor, right_b, left_xor, left_b, output ready);
endinterface

>>> design/dqsc_out_if.sv
// Result channel: motor duties, count difference and clip flag.
interface dqsc_out_if;
  import dqsc_pkg::*;

  logic      valid;
  logic      ready;
  duty_t     duty_a;
  duty_t     duty_b;
  diff_out_t count_difference;
  logic      duty_clipped;

  modport source (output valid, duty_a, duty_b, count_difference, duty_clipped, input ready);
  modport sink   (input valid, duty_a, duty_b, count_difference, duty_clipped, output ready);
endinterface

>>> design/dual_quadrature_steering_control.sv
// Top level: dual x4 quadrature decoder with proportional steering of two PWM duties.
// A result passes through the registered decode, multiply and clamp stages in order.
// Throughput: one transaction per cycle while out_ch.ready holds, set by the
// three-stage pipeline with a ready chain.
// Reset (rst_n, synchronous): counts, last levels and primed clear, registers take
// their defaults (base 30, gain 10, top 255), all stages empty.
module dual_quadrature_steering_control #(
  parameter int COUNT_WIDTH = dqsc_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  dqsc_cfg_if.sink    cfg_ch,
  dqsc_in_if.sink     in_ch,
  dqsc_out_if.source  out_ch
);
  import dqsc_pkg::*;

  localparam int W_DIFF = COUNT_WIDTH + 1;
  localparam int W_PROD = W_DIFF + GAIN_W + 1;
  localparam int W_SUM  = W_PROD + 1;
  localparam int W_X    = (W_DIFF > DIFF_OUT_W) ? W_DIFF : DIFF_OUT_W;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  // configuration
  duty_t base_duty_r;
  gain_t gain_r;
  duty_t duty_top_r;

  // decoder state
  count_t r_cnt_r, r_cnt_nxt, l_cnt_r, l_cnt_nxt;
  logic   r_la_r, r_lb_r, r_lx_r, l_la_r, l_lb_r, l_lx_r;
  logic   r_la_nxt, r_lb_nxt, l_la_nxt, l_lb_nxt;
  logic   primed_r;

  // pipeline
  logic                     s1_valid_r, s2_valid_r, out_valid_r;
  logic signed [W_DIFF-1:0] s1_diff_r, diff_nxt;
  logic signed [W_PROD-1:0] s2_prod_r, prod_nxt;
  logic signed [W_X-1:0]    s2_dext_r;
  duty_t                    duty_a_r, duty_b_r, duty_a_nxt, duty_b_nxt;
  diff_out_t                cdiff_r;
  logic                     clip_r, clip_nxt;

  logic out_free, s2_ready, s1_ready, in_acc, s1_adv, s2_adv;

  logic signed [W_PROD-1:0] prod_adj, u;
  logic signed [W_SUM-1:0]  sum_a, sum_b, top_s;

  assign cfg_ch.ready = 1'b1;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign s2_ready    = !s2_valid_r || out_free;
  assign s1_ready    = !s1_valid_r || s2_ready;
  assign in_ch.ready = s1_ready;
  assign in_acc      = in_ch.valid && s1_ready;
  assign s1_adv      = s1_valid_r && s2_ready;
  assign s2_adv      = s2_valid_r && out_free;

  function automatic count_t step_count(input count_t c, input logic a, input logic b,
                                        input logic la, input logic lb);
    count_t r;
    r = c;
    if (a == lb) begin
      r = c - count_t'(1);
    end else if (b == la) begin
      r = c + count_t'(1);
    end
    return r;
  endfunction

  always_comb begin
    r_cnt_nxt = r_cnt_r;
    l_cnt_nxt = l_cnt_r;
    r_la_nxt  = r_la_r;
    r_lb_nxt  = r_lb_r;
    l_la_nxt  = l_la_r;
    l_lb_nxt  = l_lb_r;
    if (!primed_r) begin
      r_la_nxt = in_ch.right_xor ^ in_ch.right_b;
      r_lb_nxt = in_ch.right_b;
      l_la_nxt = in_ch.left_xor ^ in_ch.left_b;
      l_lb_nxt = in_ch.left_b;
    end else begin
      if (in_ch.right_xor != r_lx_r) begin
        r_cnt_nxt = step_count(r_cnt_r, in_ch.right_xor ^ in_ch.right_b, in_ch.right_b,
                               r_la_r, r_lb_r);
        r_la_nxt  = in_ch.right_xor ^ in_ch.right_b;
        r_lb_nxt  = in_ch.right_b;
      end
      if (in_ch.left_xor != l_lx_r) begin
        l_cnt_nxt = step_count(l_cnt_r, in_ch.left_xor ^ in_ch.left_b, in_ch.left_b,
                               l_la_r, l_lb_r);
        l_la_nxt  = in_ch.left_xor ^ in_ch.left_b;
        l_lb_nxt  = in_ch.left_b;
      end
    end
    diff_nxt = $signed({r_cnt_nxt[COUNT_WIDTH-1], r_cnt_nxt})
             - $signed({l_cnt_nxt[COUNT_WIDTH-1], l_cnt_nxt});
  end

  assign prod_nxt = W_PROD'($signed({1'b0, gain_r})) * W_PROD'(s1_diff_r);

  // divide by four, truncating toward zero; then base -/+ steer, clamped to 0..top
  always_comb begin
    prod_adj = s2_prod_r[W_PROD-1] ? (s2_prod_r + W_PROD'(3)) : s2_prod_r;
    u        = prod_adj >>> 2;
    sum_a    = $signed({{(W_SUM-DUTY_W){1'b0}}, base_duty_r}) - W_SUM'(u);
    sum_b    = $signed({{(W_SUM-DUTY_W){1'b0}}, base_duty_r}) + W_SUM'(u);
    top_s    = $signed({{(W_SUM-DUTY_W){1'b0}}, duty_top_r});
    clip_nxt = 1'b0;
    if (sum_a < 0) begin
      duty_a_nxt = '0;
      clip_nxt   = 1'b1;
    end else if (sum_a > top_s) begin
      duty_a_nxt = duty_top_r;
      clip_nxt   = 1'b1;
    end else begin
      duty_a_nxt = sum_a[DUTY_W-1:0];
    end
    if (sum_b < 0) begin
      duty_b_nxt = '0;
      clip_nxt   = 1'b1;
    end else if (sum_b > top_s) begin
      duty_b_nxt = duty_top_r;
      clip_nxt   = 1'b1;
    end else begin
      duty_b_nxt = sum_b[DUTY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_duty_r <= BASE_DUTY_RST;
      gain_r      <= GAIN_RST;
      duty_top_r  <= DUTY_TOP_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_BASE_DUTY:     base_duty_r <= cfg_ch.data;
        REG_GAIN_QUARTERS: gain_r      <= cfg_ch.data[GAIN_W-1:0];
        REG_DUTY_TOP:      duty_top_r  <= cfg_ch.data;
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_cnt_r  <= '0;
      l_cnt_r  <= '0;
      r_la_r   <= 1'b0;
      r_lb_r   <= 1'b0;
      r_lx_r   <= 1'b0;
      l_la_r   <= 1'b0;
      l_lb_r   <= 1'b0;
      l_lx_r   <= 1'b0;
      primed_r <= 1'b0;
    end else if (in_acc) begin
      r_cnt_r  <= r_cnt_nxt;
      l_cnt_r  <= l_cnt_nxt;
      r_la_r   <= r_la_nxt;
      r_lb_r   <= r_lb_nxt;
      r_lx_r   <= in_ch.right_xor;
      l_la_r   <= l_la_nxt;
      l_lb_r   <= l_lb_nxt;
      l_lx_r   <= in_ch.left_xor;
      primed_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= in_acc || (s1_valid_r && !s2_ready);
      s2_valid_r  <= s1_adv || (s2_valid_r && !out_free);
      out_valid_r <= s2_adv || (out_valid_r && !out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_diff_r <= diff_nxt;
    end
    if (s1_adv) begin
      s2_prod_r <= prod_nxt;
      s2_dext_r <= W_X'(s1_diff_r);
    end
    if (s2_adv) begin
      duty_a_r <= duty_a_nxt;
      duty_b_r <= duty_b_nxt;
      cdiff_r  <= s2_dext_r[DIFF_OUT_W-1:0];
      clip_r   <= clip_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.duty_a           = duty_a_r;
  assign out_ch.duty_b           = duty_b_r;
  assign out_ch.count_difference = cdiff_r;
  assign out_ch.duty_clipped     = clip_r;

`ifndef SYNTHESIS
  a_unprimed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !primed_r |-> (r_cnt_r == '0) && (l_cnt_r == '0))
    else $error("counts moved before the first sample");

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted transaction not held in decode stage");

  a_s2_held: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && !out_free |=> s2_valid_r && $stable(s2_prod_r))
    else $error("multiply stage lost a transaction under stall");

  a_s1_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s2_ready |=> s1_valid_r && $stable(s1_diff_r))
    else $error("decode stage lost a transaction under stall");
`endif

endmodule

>>> tb/tb_dual_quadrature_steering_control.sv
// Self-checking testbench: quadrature decode and steering duties checked against a predictor.
module tb_dual_quadrature_steering_control;
  timeunit 1ns;
  timeprecision 1ps;

  import dqsc_pkg::*;

  localparam int CNT_W = COUNT_WIDTH_DEF;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SWEEP_STEPS = 200;
  localparam int PHASE_ITEMS = 110;
  localparam cfg_idx_t REG_UNUSED = 2'd3;

  typedef struct packed {
    logic right_xor;
    logic right_b;
    logic left_xor;
    logic left_b;
  } pin_sample_t;

  typedef struct packed {
    duty_t     duty_a;
    duty_t     duty_b;
    diff_out_t count_difference;
    logic      duty_clipped;
  } steer_result_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             last_a;
    logic             last_b;
    logic             last_xor;
  } wheel_state_t;

  class steering_scoreboard;
    duty_t         base_duty;
    gain_t         gain_quarters;
    duty_t         duty_top;
    wheel_state_t  right_wheel;
    wheel_state_t  left_wheel;
    bit            primed;
    steer_result_t expected_steering[$];
    int            errors;

    function new();
      base_duty     = BASE_DUTY_RST;
      gain_quarters = GAIN_RST;
      duty_top      = DUTY_TOP_RST;
      right_wheel   = '0;
      left_wheel    = '0;
      primed        = 1'b0;
      errors        = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, cfg_data_t data);
      case (idx)
        REG_BASE_DUTY: begin
          base_duty = data;
        end
        REG_GAIN_QUARTERS: begin
          gain_quarters = data[GAIN_W-1:0];
        end
        REG_DUTY_TOP: begin
          duty_top = data;
        end
        default: begin
        end
      endcase
    endfunction

    function wheel_state_t prime_wheel(wheel_state_t w, logic x, logic b);
      w.last_xor = x;
      w.last_b   = b;
      w.last_a   = x ^ b;
      return w;
    endfunction

    function wheel_state_t decode_wheel(wheel_state_t w, logic x, logic b);
      logic a;
      a = x ^ b;
      if (x != w.last_xor) begin
        if (a == w.last_b) w.count = w.count - 1'b1;
        else if (b == w.last_a) w.count = w.count + 1'b1;
        w.last_a = a;
        w.last_b = b;
      end
      w.last_xor = x;
      return w;
    endfunction

    // {clipped, duty}
    function logic [DUTY_W:0] clamp_duty(longint d);
      if (d < 0) return {1'b1, duty_t'(0)};
      if (d > longint'(duty_top)) return {1'b1, duty_top};
      return {1'b0, duty_t'(d)};
    endfunction

    function void note_sample(pin_sample_t s);
      longint           diff;
      longint           steer;
      logic [DUTY_W:0]  da;
      logic [DUTY_W:0]  db;
      steer_result_t    exp;
      if (!primed) begin
        right_wheel = prime_wheel(right_wheel, s.right_xor, s.right_b);
        left_wheel  = prime_wheel(left_wheel, s.left_xor, s.left_b);
        primed      = 1'b1;
      end else begin
        right_wheel = decode_wheel(right_wheel, s.right_xor, s.right_b);
        left_wheel  = decode_wheel(left_wheel, s.left_xor, s.left_b);
      end
      diff  = longint'($signed(right_wheel.count)) - longint'($signed(left_wheel.count));
      steer = (longint'(gain_quarters) * diff) / 4;
      da    = clamp_duty(longint'(base_duty) - steer);
      db    = clamp_duty(longint'(base_duty) + steer);
      exp.duty_a           = da[DUTY_W-1:0];
      exp.duty_b           = db[DUTY_W-1:0];
      exp.count_difference = diff_out_t'(diff);
      exp.duty_clipped     = da[DUTY_W] | db[DUTY_W];
      expected_steering.push_back(exp);
    endfunction

    function void check_result(steer_result_t got);
      steer_result_t exp;
      if (expected_steering.size() == 0) begin
        $error("unexpected result transaction: duty_a=%0d duty_b=%0d diff=%0d clip=%0b",
               got.duty_a, got.duty_b, got.count_difference, got.duty_clipped);
        errors++;
        return;
      end
      exp = expected_steering.pop_front();
      if (got.duty_a !== exp.duty_a) begin
        $error("duty_a: expected %0d, got %0d", exp.duty_a, got.duty_a);
        errors++;
      end
      if (got.duty_b !== exp.duty_b) begin
        $error("duty_b: expected %0d, got %0d", exp.duty_b, got.duty_b);
        errors++;
      end
      if (got.count_difference !== exp.count_difference) begin
        $error("count_difference: expected %0d, got %0d",
               exp.count_difference, got.count_difference);
        errors++;
      end
      if (got.duty_clipped !== exp.duty_clipped) begin
        $error("duty_clipped: expected %0b, got %0b", exp.duty_clipped, got.duty_clipped);
        errors++;
      end
    endfunction

    function int pending();
      return expected_steering.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   cycle_count = 0;
  bit   src_idle;
  bit   snk_idle;
  int   right_phase;
  int   left_phase;

  steering_scoreboard sb;

  dqsc_cfg_if cfg_ch ();
  dqsc_in_if  in_ch ();
  dqsc_out_if out_ch ();

  dual_quadrature_steering_control i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // quadrature phase 0..3 -> (A,B) = 00,10,11,01; increasing phase counts up
  function automatic logic phase_a(int p);
    return (p == 1) || (p == 2);
  endfunction

  function automatic logic phase_b(int p);
    return (p == 2) || (p == 3);
  endfunction

  function automatic int next_phase(int p, int bias);
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return (p + bias + 4) % 4;
    if (r < 75) return (p - bias + 4) % 4;
    if (r < 88) return p;
    if (r < 95) return (p + 2) % 4;
    return $urandom_range(0, 3);
  endfunction

  task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic send_sample(pin_sample_t s);
    int gap;
    gap = src_idle ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.right_xor = s.right_xor;
    in_ch.right_b   = s.right_b;
    in_ch.left_xor  = s.left_xor;
    in_ch.left_b    = s.left_b;
    in_ch.valid     = 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_sample(s);
  endtask

  task automatic send_phases();
    pin_sample_t s;
    s.right_xor = phase_a(right_phase) ^ phase_b(right_phase);
    s.right_b   = phase_b(right_phase);
    s.left_xor  = phase_a(left_phase) ^ phase_b(left_phase);
    s.left_b    = phase_b(left_phase);
    send_sample(s);
  endtask

  task automatic step_wheels(int right_dir, int left_dir, int n);
    repeat (n) begin
      right_phase = (right_phase + right_dir + 4) % 4;
      left_phase  = (left_phase + left_dir + 4) % 4;
      send_phases();
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic run_phase(cfg_data_t base, cfg_data_t gain, cfg_data_t top, bit idle);
    int bias;
    write_reg(REG_BASE_DUTY, base);
    write_reg(REG_GAIN_QUARTERS, gain);
    write_reg(REG_DUTY_TOP, top);
    src_idle = idle;
    snk_idle = idle;
    bias = $urandom_range(0, 1) ? 1 : -1;
    repeat (PHASE_ITEMS) begin
      right_phase = next_phase(right_phase, bias);
      left_phase  = next_phase(left_phase, -bias);
      send_phases();
    end
    drain();
  endtask

  // result side: random stalls, check on every accepted transaction
  initial begin
    int            stall;
    steer_result_t got;
    stall = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall == 0 && snk_idle && $urandom_range(0, 3) == 0) stall = pick_gap();
      out_ch.ready = (stall == 0);
      if (stall > 0) stall--;
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.duty_a           = out_ch.duty_a;
        got.duty_b           = out_ch.duty_b;
        got.count_difference = out_ch.count_difference;
        got.duty_clipped     = out_ch.duty_clipped;
        sb.check_result(got);
      end
    end
  end

  initial begin
    sb = new();
    rst_n           = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_BASE_DUTY;
    cfg_ch.data     = '0;
    in_ch.valid     = 1'b0;
    in_ch.right_xor = 1'b0;
    in_ch.right_b   = 1'b0;
    in_ch.left_xor  = 1'b0;
    in_ch.left_b    = 1'b0;
    src_idle        = 1'b1;
    snk_idle        = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed, default registers; first sample primes from non-zero pins
    right_phase = 2;
    left_phase  = 3;
    send_phases();
    step_wheels(1, -1, 4);
    step_wheels(-1, 1, 2);
    step_wheels(0, 0, 1);
    step_wheels(2, 2, 1);
    step_wheels(1, 1, 2);
    step_wheels(-1, -1, 3);
    right_phase = 3;
    left_phase  = 3;
    send_phases();
    right_phase = 0;
    left_phase  = 0;
    send_phases();
    step_wheels(-1, 1, 3);
    drain();

    write_reg(REG_UNUSED, cfg_data_t'($urandom));

    run_phase(16'd0, 16'd255, 16'hFFFF, 1'b1);
    run_phase(16'hFFFF, 16'd0, 16'hFFFF, 1'b0);
    run_phase(16'hFFFF, 16'd255, 16'd1, 1'b1);
    run_phase(16'd128, 16'h3F04, 16'd255, 1'b1);
    run_phase(16'd100, 16'd7, 16'd0, 1'b1);

    // steady back-to-back sweep, wheels turning in opposite directions
    write_reg(REG_BASE_DUTY, 16'd32768);
    write_reg(REG_GAIN_QUARTERS, 16'd3);
    write_reg(REG_DUTY_TOP, 16'hFFFF);
    src_idle = 1'b0;
    snk_idle = 1'b0;
    step_wheels(1, -1, SWEEP_STEPS);
    drain();

    write_reg(REG_UNUSED, cfg_data_t'($urandom));
    repeat (3) begin
      run_phase(cfg_data_t'($urandom), cfg_data_t'($urandom), cfg_data_t'($urandom), 1'b1);
    end
    run_phase(16'd30, 16'd10, 16'd255, 1'b1);

    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
